// ===== src/fcv_pkg.sv =====
// Shared types, constants and the checksum fold for the frame check validator.
package fcv_pkg;

   // Payload widths.
   localparam int BYTE_W      = 8;
   localparam int SUM_W       = 16;
   localparam int CSR_INDEX_W = 8;

   // Frame layout constants.
   localparam int MIN_FRAME_BYTES = 5;
   localparam int PARAM_BASE      = 7;
   localparam int SUM_FIRST_BYTE  = 2;
   localparam int COUNT_BYTE      = 2;
   localparam logic [BYTE_W-1:0] MOD_BASE = 8'd255;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_FIRST   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_SECOND  = 8'd3;

   // Marker bytes that the frame is checked against.
   typedef struct packed {
      logic [BYTE_W-1:0] start_first;
      logic [BYTE_W-1:0] start_second;
      logic [BYTE_W-1:0] stop_first;
      logic [BYTE_W-1:0] stop_second;
   } fcv_cfg_type;

   // Reduce the sum modulo 255 when it exceeds 255, keep it otherwise.
   // Since 256 is 1 mod 255, two folds of high byte onto low byte suffice.
   function automatic logic [BYTE_W-1:0] fold_sum(input logic [SUM_W-1:0] sum);
      logic [BYTE_W:0] first_fold;
      logic [BYTE_W:0] second_fold;
      logic [BYTE_W-1:0] result;
      first_fold  = {1'b0, sum[SUM_W-1:BYTE_W]} + {1'b0, sum[BYTE_W-1:0]};
      second_fold = {{BYTE_W{1'b0}}, first_fold[BYTE_W]} + {1'b0, first_fold[BYTE_W-1:0]};
      if (sum[SUM_W-1:BYTE_W] == '0) begin
         result = sum[BYTE_W-1:0];
      end else if (second_fold[BYTE_W-1:0] == MOD_BASE) begin
         result = '0;
      end else begin
         result = second_fold[BYTE_W-1:0];
      end
      return result;
   endfunction

endpackage

// ===== src/fcv_channels.sv =====
// Handshake channel interfaces for the request, response and register write paths.
interface fcv_req_if;
   logic                       valid;
   logic                       ready;
   logic [fcv_pkg::BYTE_W-1:0] data_byte;
   logic                       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface fcv_rsp_if;
   logic valid;
   logic ready;
   logic frame_valid;

   modport source (output valid, output frame_valid, input ready);
   modport sink   (input valid, input frame_valid, output ready);
endinterface

interface fcv_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fcv_pkg::CSR_INDEX_W-1:0] index;
   logic [fcv_pkg::BYTE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/frame_check_validator.sv =====
// Top level of the frame check validator: input register, frame tracker, result register.
//
// Usage: frame bytes arrive on the req channel, one byte per transfer, with
// frame_end set on the last byte of a frame. For every byte with frame_end
// set, one transfer leaves on the rsp channel carrying frame_valid; other
// bytes produce nothing. Bytes 0 and 1 must match the start registers, the
// last two bytes the stop registers, and the folded checksum of bytes 2
// through 6+count must equal the third-last byte.
// The csr channel writes the four marker registers (indexes 0 to 3; higher
// indexes are dropped). It is always ready; write it only while no frame
// is in flight.
// A final byte passes through the input register, then its verdict is loaded
// into the result register. One byte is taken every cycle unless a final byte
// is blocked, as set by the single input register feeding the frame tracker.
// When the receiver stalls, the pending result stays in the result
// register; further non-final bytes keep flowing, and a following final
// byte waits in the input register, which then drops req.ready.
// Reset clears the marker registers, the frame state and both registers'
// valid flags.
module frame_check_validator #(
   parameter int MAX_FRAME_BYTES = 511
) (
   input logic      clock,
   input logic      reset,
   fcv_req_if.sink  req,
   fcv_rsp_if.source rsp,
   fcv_csr_if.sink  csr
);
   import fcv_pkg::*;

   fcv_cfg_type cfg;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;
   logic              out_valid_ff, out_valid_in;
   logic              out_data_ff;
   logic              advance;
   logic              rsp_load;
   logic              verdict;

   fcv_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   fcv_frame_track #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame_track (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .frame_end (in_end_ff),
      .cfg       (cfg),
      .verdict   (verdict)
   );

   // A byte leaves the input register unless it is final and the result slot is busy.
   always_comb begin
      advance      = in_valid_ff && (!in_end_ff || !out_valid_ff || rsp.ready);
      rsp_load     = advance && in_end_ff;
      in_valid_in  = req.valid || (in_valid_ff && !advance);
      out_valid_in = rsp_load || (out_valid_ff && !rsp.ready);
   end

   assign req.ready       = !in_valid_ff || advance;
   assign rsp.valid       = out_valid_ff;
   assign rsp.frame_valid = out_data_ff;

   // Input register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data_byte;
         in_end_ff  <= req.frame_end;
      end
      if (rsp_load) begin
         out_data_ff <= verdict;
      end
   end

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("result offered right after reset");

   // A result is only loaded from a final byte.
   assert property (@(posedge clock) disable iff (reset) rsp_load |-> in_end_ff)
      else $error("result loaded from a non-final byte");

   // Back-pressure on req only comes from a final byte blocked by a busy result slot.
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (in_valid_ff && in_end_ff && out_valid_ff && !rsp.ready))
      else $error("input stalled without a blocked final byte");

endmodule

// ===== src/fcv_csr_regs.sv =====
// Marker byte registers written through the register write channel.
module fcv_csr_regs (
   input  logic                 clock,
   input  logic                 reset,
   fcv_csr_if.sink              csr,
   output fcv_pkg::fcv_cfg_type cfg
);
   import fcv_pkg::*;

   fcv_cfg_type cfg_ff;
   fcv_cfg_type cfg_in;

   // Writes are always taken; unknown indexes are dropped.
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_START_FIRST:  cfg_in.start_first  = csr.data;
            CSR_START_SECOND: cfg_in.start_second = csr.data;
            CSR_STOP_FIRST:   cfg_in.stop_first   = csr.data;
            CSR_STOP_SECOND:  cfg_in.stop_second  = csr.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/fcv_frame_track.sv =====
// Per-frame state: position, parameter count, running sum, recent bytes and the verdict.
module fcv_frame_track #(
   parameter int MAX_FRAME_BYTES = 511
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [fcv_pkg::BYTE_W-1:0] data_byte,
   input  logic                       frame_end,
   input  fcv_pkg::fcv_cfg_type       cfg,
   output logic                       verdict
);
   import fcv_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMP_W = ((POS_W > BYTE_W) ? POS_W : BYTE_W) + 1;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] recent_ff [2];
   logic              start_ok_ff, start_ok_in;
   logic              overflow_ff, overflow_in;

   logic             saturated;
   logic [CMP_W-1:0] pos_wide;
   logic [CMP_W-1:0] pos_next_wide;
   logic [CMP_W-1:0] sum_limit;
   logic             in_sum_range;

   // Advance the frame state by one byte.
   always_comb begin
      saturated   = (pos_ff >= POS_W'(MAX_FRAME_BYTES));
      pos_in      = saturated ? pos_ff : pos_ff + POS_W'(1);
      overflow_in = overflow_ff | saturated;
      pos_wide    = CMP_W'(pos_ff);

      count_in = count_ff;
      if (!saturated && pos_ff == POS_W'(COUNT_BYTE)) begin
         count_in = data_byte;
      end

      start_ok_in = start_ok_ff;
      if (!saturated && pos_ff == '0) begin
         start_ok_in = (data_byte == cfg.start_first);
      end else if (!saturated && pos_ff == POS_W'(1)) begin
         start_ok_in = start_ok_ff && (data_byte == cfg.start_second);
      end

      sum_limit    = CMP_W'(PARAM_BASE) + CMP_W'(count_in);
      in_sum_range = !saturated && (pos_wide >= CMP_W'(SUM_FIRST_BYTE))
                     && (pos_wide < sum_limit);
      sum_in       = in_sum_range ? sum_ff + SUM_W'(data_byte) : sum_ff;

      // Verdict on the last byte, using the state after this byte.
      pos_next_wide = CMP_W'(pos_in);
      verdict = !overflow_in
                && (pos_next_wide >= CMP_W'(MIN_FRAME_BYTES))
                && (pos_next_wide >= sum_limit)
                && start_ok_in
                && (data_byte == cfg.stop_second)
                && (recent_ff[0] == cfg.stop_first)
                && (fold_sum(sum_in) == recent_ff[1]);
   end

   // State registers; the frame state clears after its last byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         recent_ff[0] <= '0;
         recent_ff[1] <= '0;
         start_ok_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
      end else if (step) begin
         if (frame_end) begin
            pos_ff       <= '0;
            count_ff     <= '0;
            sum_ff       <= '0;
            recent_ff[0] <= '0;
            recent_ff[1] <= '0;
            start_ok_ff  <= 1'b0;
            overflow_ff  <= 1'b0;
         end else begin
            pos_ff       <= pos_in;
            count_ff     <= count_in;
            sum_ff       <= sum_in;
            recent_ff[0] <= data_byte;
            recent_ff[1] <= recent_ff[0];
            start_ok_ff  <= start_ok_in;
            overflow_ff  <= overflow_in;
         end
      end
   end

endmodule

// ===== test/fcv_frame_checker.sv =====
// Checker that predicts frame verdicts from observed transfers and compares them with results.
`timescale 1ns / 1ps
module fcv_frame_checker #(
   parameter int MAX_FRAME_BYTES = 511
) (
   input  logic clock,
   input  logic reset,
   fcv_req_if   req,
   fcv_rsp_if   rsp,
   fcv_csr_if   csr,
   output int   fail_count,
   output int   verdicts_pending
);
   import fcv_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

   // Predicted copy of the marker registers and the per-frame state.
   fcv_cfg_type       markers;
   logic [POS_W-1:0]  position;
   logic [BYTE_W-1:0] param_count;
   logic [SUM_W-1:0]  frame_sum;
   logic [BYTE_W-1:0] tail_bytes [3];
   logic              start_ok;
   logic              overran;
   bit                expected_verdicts [$];

   task automatic clear_frame_state();
      position      = '0;
      param_count   = '0;
      frame_sum     = '0;
      tail_bytes[0] = '0;
      tail_bytes[1] = '0;
      tail_bytes[2] = '0;
      start_ok      = 1'b0;
      overran       = 1'b0;
   endtask

   // Advance the frame state by one byte; on the last byte queue the verdict.
   task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
      logic [SUM_W-1:0] folded;
      bit               verdict;
      tail_bytes[2] = tail_bytes[1];
      tail_bytes[1] = tail_bytes[0];
      tail_bytes[0] = b;
      if (int'(position) >= MAX_FRAME_BYTES) begin
         overran = 1'b1;
      end else begin
         if (position == 0) begin
            start_ok = (b == markers.start_first);
         end else if (position == 1) begin
            start_ok = start_ok && (b == markers.start_second);
         end
         if (position == COUNT_BYTE) begin
            param_count = b;
         end
         if (int'(position) >= SUM_FIRST_BYTE &&
             int'(position) < PARAM_BASE + int'(param_count)) begin
            frame_sum = frame_sum + SUM_W'(b);
         end
         position = position + 1'b1;
      end
      if (last) begin
         // The sum is only reduced once it no longer fits in a byte.
         folded  = (frame_sum > SUM_W'(MOD_BASE)) ? frame_sum % SUM_W'(MOD_BASE) : frame_sum;
         verdict = !overran
                   && int'(position) >= MIN_FRAME_BYTES
                   && int'(position) >= PARAM_BASE + int'(param_count)
                   && start_ok
                   && tail_bytes[0] == markers.stop_second
                   && tail_bytes[1] == markers.stop_first
                   && folded[BYTE_W-1:0] == tail_bytes[2];
         expected_verdicts.push_back(verdict);
         clear_frame_state();
      end
   endtask

   // Sample every channel at the clock edge and compare results in order.
   always @(posedge clock) begin
      bit want;
      if (reset) begin
         markers    = '0;
         fail_count = 0;
         clear_frame_state();
         expected_verdicts.delete();
      end else begin
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t ns: result transfer with none expected, expected none, actual %b",
                        $time, rsp.frame_valid);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp.frame_valid !== want) begin
                  fail_count++;
                  $display("%0t ns: frame_valid mismatch, expected %b, actual %b",
                           $time, want, rsp.frame_valid);
               end
            end
         end
         if (csr.valid === 1'b1 && csr.ready === 1'b1) begin
            case (csr.index)
               CSR_START_FIRST:  markers.start_first  = csr.data;
               CSR_START_SECOND: markers.start_second = csr.data;
               CSR_STOP_FIRST:   markers.stop_first   = csr.data;
               CSR_STOP_SECOND:  markers.stop_second  = csr.data;
               default: ;
            endcase
         end
         if (req.valid === 1'b1 && req.ready === 1'b1) begin
            absorb_byte(req.data_byte, req.frame_end);
         end
      end
      verdicts_pending <= expected_verdicts.size();
   end

endmodule

// ===== test/tb.sv =====
// Top of the frame check validator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
   import fcv_pkg::*;

   localparam int MAX_FRAME_BYTES = 511;
   localparam int RESET_CYCLES    = 10;
   localparam int PHASES          = 6;
   localparam int PHASE_BYTES     = 64;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int LONG_COUNT      = 255;
   localparam int FRAME_OVERHEAD  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW  = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HIGH = 8'hFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   verdicts_pending;
   int   cycle_count = 0;
   int   bytes_sent;
   bit   hold_request   = 1'b0;
   bit   sender_burst   = 1'b0;
   bit   receiver_burst = 1'b0;

   fcv_cfg_type       markers;
   logic [BYTE_W-1:0] frame_buf [$];

   fcv_req_if req_chan ();
   fcv_rsp_if rsp_chan ();
   fcv_csr_if csr_chan ();

   frame_check_validator #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .csr   (csr_chan)
   );

   fcv_frame_checker #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) frame_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .csr              (csr_chan),
      .fail_count       (fail_count),
      .verdicts_pending (verdicts_pending)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog in case the block stops moving.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Checksum byte a sender places in front of the stop markers.
   function automatic logic [BYTE_W-1:0] checksum_byte(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s > SUM_W'(MOD_BASE)) ? s % SUM_W'(MOD_BASE) : s;
      return r[BYTE_W-1:0];
   endfunction

   // One byte transfer after an optional idle gap; valid stays high afterwards.
   task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last, input int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.frame_end <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      bytes_sent++;
   endtask

   task automatic send_frame();
      bit burst;
      burst = sender_burst || ($urandom_range(0, 3) == 0);
      foreach (frame_buf[i]) begin
         put_byte(frame_buf[i], i == frame_buf.size() - 1, burst ? 0 : $urandom_range(0, 9));
      end
   endtask

   // Build a well-formed frame for the current markers. With overlap set the
   // frame is as short as its parameters allow, so the checksum byte is itself
   // summed; a value that matches its own fold is searched for.
   task automatic build_frame(input int count, input int pad, input bit overlap,
                              input bit saturate);
      logic [SUM_W-1:0]  sum;
      logic [BYTE_W-1:0] pick;
      frame_buf.delete();
      frame_buf.push_back(markers.start_first);
      frame_buf.push_back(markers.start_second);
      frame_buf.push_back(BYTE_W'(count));
      sum = '0;
      if (overlap) begin
         repeat (count + 1) frame_buf.push_back(BYTE_W'($urandom));
         for (int i = SUM_FIRST_BYTE; i < frame_buf.size(); i++) begin
            sum = sum + SUM_W'(frame_buf[i]);
         end
         sum  = sum + SUM_W'(markers.stop_first) + SUM_W'(markers.stop_second);
         pick = BYTE_W'($urandom);
         for (int x = 0; x < 256; x++) begin
            if (checksum_byte(SUM_W'(sum + x)) == BYTE_W'(x)) begin
               pick = BYTE_W'(x);
            end
         end
         frame_buf.push_back(pick);
      end else begin
         repeat (count + 4) frame_buf.push_back(saturate ? 8'hFF : BYTE_W'($urandom));
         for (int i = SUM_FIRST_BYTE; i < frame_buf.size(); i++) begin
            sum = sum + SUM_W'(frame_buf[i]);
         end
         repeat (pad) frame_buf.push_back(BYTE_W'($urandom));
         frame_buf.push_back(checksum_byte(sum));
      end
      frame_buf.push_back(markers.stop_first);
      frame_buf.push_back(markers.stop_second);
   endtask

   // Mostly good frames with random content, the rest damaged frames and noise.
   task automatic random_frame();
      int pick;
      int count;
      int pos;
      int keep;
      pick  = $urandom_range(0, 99);
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      build_frame(count, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                  $urandom_range(0, 6) == 0, 1'b0);
      if (pick >= 60 && pick < 72) begin
         // Flip a single bit somewhere in the frame.
         pos = $urandom_range(0, frame_buf.size() - 1);
         frame_buf[pos] = frame_buf[pos] ^ BYTE_W'(1 << $urandom_range(0, BYTE_W - 1));
      end else if (pick >= 72 && pick < 84) begin
         // Cut the frame short, possibly below the minimum length.
         keep = $urandom_range(1, frame_buf.size() - 1);
         while (frame_buf.size() > keep) void'(frame_buf.pop_back());
      end else if (pick >= 84) begin
         frame_buf.delete();
         repeat ($urandom_range(1, 12)) frame_buf.push_back(BYTE_W'($urandom));
      end
      send_frame();
   endtask

   // Register write; valid is left high so back-to-back writes stay clean.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [BYTE_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
   endtask

   task automatic write_markers(input fcv_cfg_type m, input bit touch_unused);
      markers = m;
      csr_write(CSR_START_FIRST, m.start_first);
      csr_write(CSR_START_SECOND, m.start_second);
      csr_write(CSR_STOP_FIRST, m.stop_first);
      csr_write(CSR_STOP_SECOND, m.stop_second);
      if (touch_unused) begin
         csr_write(CSR_UNUSED_LOW, BYTE_W'($urandom));
         csr_write(CSR_UNUSED_HIGH, BYTE_W'($urandom));
      end
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Let every outstanding verdict arrive and the pipeline drain.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result receiver with random stalls and one long hold-off on request.
   initial begin
      int stall;
      bit hold_done;
      rsp_chan.ready <= 1'b0;
      hold_done = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            receiver_burst = !receiver_burst;
         end
         stall = receiver_burst ? 0 : $urandom_range(0, 9);
         if (hold_request && !hold_done) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Main stimulus.
   initial begin
      int          short_lengths [5] = '{1, 4, 5, 6, 7};
      fcv_cfg_type m;
      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.frame_end <= 1'b0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= '0;
      csr_chan.data      <= '0;
      markers = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // All-zero frames against the reset markers: too short, truncated
      // parameters, and the shortest complete frame whose checksum byte is summed.
      foreach (short_lengths[k]) begin
         frame_buf.delete();
         repeat (short_lengths[k]) frame_buf.push_back(8'h00);
         send_frame();
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0:       m = '1;
            1:       m = '0;
            default: m = fcv_cfg_type'($urandom);
         endcase
         write_markers(m, phase % 2 == 1);
         sender_burst = (phase == 2);
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         // Longest frame that still fits, with a sum that wraps past 16 bits.
         if (phase == 3) begin
            build_frame(LONG_COUNT, MAX_FRAME_BYTES - FRAME_OVERHEAD - LONG_COUNT, 1'b0, 1'b1);
            send_frame();
         end
         // One byte more than the position can count.
         if (phase == 4) begin
            build_frame(LONG_COUNT, MAX_FRAME_BYTES + 1 - FRAME_OVERHEAD - LONG_COUNT,
                        1'b0, 1'b1);
            send_frame();
         end
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) random_frame();
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
